// ===== hdl/sacl_pkg.sv =====
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int SET_W      = 5;
  localparam int OFF_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED      = 2'd2;

  localparam logic [2:0] OFF_BITS_MAX = 3'd6;
  localparam logic [2:0] SET_BITS_MAX = 3'd5;

  typedef struct packed {
    logic [2:0] line_size_log2;
    logic [2:0] set_count_log2;
    logic [3:0] ways_used;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_idx;
    logic [OFF_W-1:0] offset;
  } req_t;

endpackage

`default_nettype wire

// ===== hdl/set_assoc_cache_tag_lookup_top.sv =====
// Set-associative tag lookup.
// Input: one byte address per beat on in_address, taken when start is high
// and busy is low. busy stays low, so a beat can be taken on every cycle.
// Output: out_valid strobes for one cycle with out_hit, out_tag_value,
// out_set_index and out_line_offset; the receiver cannot stall the block.
// A beat is registered in the split stage's request register and then in
// the output register; throughput is one beat per cycle. The tag RAM has
// one row per set and a registered read, which sets the first stage;
// compare, way select and the row write-back take the second, with the
// last written row forwarded to the next beat.
// Config: cfg_valid/cfg_ready (always ready), cfg_index selects line size,
// set count or ways in use; other indices are ignored. Write only when idle.
// Reset (synchronous, rst_n low) clears all valid bits and the pipeline and
// loads line size 4 bytes, one set and all ways in use. No clearing pass.
`default_nettype none

module set_assoc_cache_tag_lookup_top #(
  parameter int SETS      = 32,
  parameter int WAYS      = 8,
  parameter int ADDR_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [sacl_pkg::ADDR_W-1:0]       in_address,
  output logic                                   out_valid,
  output logic                                   out_hit,
  output logic      [sacl_pkg::TAG_W-1:0]        out_tag_value,
  output logic      [sacl_pkg::SET_W-1:0]        out_set_index,
  output logic      [sacl_pkg::OFF_W-1:0]        out_line_offset,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import sacl_pkg::*;

  localparam int SIW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AW  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int RW  = WAYS * AW;

  cfg_t           cfg_r;
  cfg_t           cfg_nxt;
  req_t           req;
  logic           accept;
  logic           rd_en;
  logic [SIW-1:0] rd_addr;
  logic [RW-1:0]  rd_data;
  logic           wr_en;
  logic [SIW-1:0] wr_addr;
  logic [RW-1:0]  wr_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_SIZE_LOG2: cfg_nxt.line_size_log2 = cfg_data[2:0];
        REG_SET_COUNT_LOG2: cfg_nxt.set_count_log2 = cfg_data[2:0];
        REG_WAYS_USED:      cfg_nxt.ways_used      = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_size_log2 <= 3'd2;
      cfg_r.set_count_log2 <= 3'd0;
      cfg_r.ways_used      <= 4'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sacl_split #(
    .SETS      (SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .address (in_address),
    .cfg     (cfg_r),
    .req     (req),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  sacl_ram #(
    .WIDTH (RW),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sacl_lookup #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_lookup (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .cfg             (cfg_r),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_tag_value   (out_tag_value),
    .out_set_index   (out_set_index),
    .out_line_offset (out_line_offset)
  );

endmodule

`default_nettype wire

// ===== hdl/sacl_ram.sv =====
`default_nettype none

module sacl_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/sacl_split.sv =====
`default_nettype none

module sacl_split #(
  parameter int  SETS      = 32,
  parameter int  ADDR_BITS = 32,
  localparam int SIW       = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [sacl_pkg::ADDR_W-1:0]  address,
  input  wire sacl_pkg::cfg_t               cfg,
  output sacl_pkg::req_t                    req,
  output logic                              rd_en,
  output logic      [SIW-1:0]               rd_addr
);

  import sacl_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                            ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [SET_W-1:0]  SET_LIM   = (SETS >= 32) ? {SET_W{1'b1}} : SET_W'(SETS - 1);

  logic [ADDR_W-1:0] addr_m;
  logic [ADDR_W-1:0] addr_sh;
  logic [2:0]        off_bits;
  logic [2:0]        set_bits;
  logic [3:0]        tag_sh;
  logic [OFF_W-1:0]  offset;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag;
  logic [SIW+SET_W-1:0] set_ext;
  req_t              req_r;

  always_comb begin
    addr_m   = address & ADDR_MASK;
    off_bits = (cfg.line_size_log2 > OFF_BITS_MAX) ? OFF_BITS_MAX : cfg.line_size_log2;
    set_bits = (cfg.set_count_log2 > SET_BITS_MAX) ? SET_BITS_MAX : cfg.set_count_log2;
    offset   = addr_m[OFF_W-1:0] & ~({OFF_W{1'b1}} << off_bits);
    addr_sh  = addr_m >> off_bits;
    set_idx  = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << set_bits) & SET_LIM;
    tag_sh   = {1'b0, off_bits} + {1'b0, set_bits};
    tag      = addr_m >> tag_sh;
    set_ext  = {{SIW{1'b0}}, set_idx};
  end

  assign rd_en   = accept;
  assign rd_addr = set_ext[SIW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else begin
      req_r.valid <= accept;
    end
    if (accept) begin
      req_r.tag     <= tag;
      req_r.set_idx <= set_idx;
      req_r.offset  <= offset;
    end
  end

  assign req = req_r;

endmodule

`default_nettype wire

// ===== hdl/sacl_lookup.sv =====
`default_nettype none

module sacl_lookup #(
  parameter int  SETS      = 32,
  parameter int  WAYS      = 8,
  parameter int  ADDR_BITS = 32,
  localparam int SIW       = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int AW        = (ADDR_BITS < 32) ? ADDR_BITS : 32,
  localparam int RW        = WAYS * AW
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sacl_pkg::req_t               req,
  input  wire sacl_pkg::cfg_t               cfg,
  input  wire logic [RW-1:0]                rd_data,
  output logic                              wr_en,
  output logic      [SIW-1:0]               wr_addr,
  output logic      [RW-1:0]                wr_data,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic      [sacl_pkg::TAG_W-1:0]   out_tag_value,
  output logic      [sacl_pkg::SET_W-1:0]   out_set_index,
  output logic      [sacl_pkg::OFF_W-1:0]   out_line_offset
);

  import sacl_pkg::*;

  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCW = $clog2(WAYS + 1);

  logic [WAYS-1:0]      valid_r [SETS];
  logic                 byp_vld_r;
  logic [SIW-1:0]       byp_set_r;
  logic [RW-1:0]        byp_row_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [SET_W-1:0]     out_set_r;
  logic [OFF_W-1:0]     out_off_r;

  logic [SIW+SET_W-1:0] set_ext;
  logic [SIW-1:0]       sidx;
  logic [RW-1:0]        row_cur;
  logic [RW-1:0]        row_nxt;
  logic [WAYS-1:0]      vrow;
  logic [AW-1:0]        tag_w;
  logic [AW-1:0]        req_tag;
  logic [WCW-1:0]       ways_eff;
  logic [WW-1:0]        last_way;
  logic [WW-1:0]        first_way;
  logic [WW-1:0]        wr_way;
  logic                 found;
  logic                 hit;
  logic                 match_w;

  always_comb begin
    set_ext = {{SIW{1'b0}}, req.set_idx};
    sidx    = set_ext[SIW-1:0];
    req_tag = req.tag[AW-1:0];
    vrow    = valid_r[sidx];
    row_cur = (byp_vld_r && (byp_set_r == sidx)) ? byp_row_r : rd_data;

    if (cfg.ways_used == 4'd0) begin
      ways_eff = WCW'(1);
    end else if (32'(cfg.ways_used) > 32'(WAYS)) begin
      ways_eff = WCW'(WAYS);
    end else begin
      ways_eff = WCW'(cfg.ways_used);
    end
    last_way = WW'(ways_eff - WCW'(1));

    found     = 1'b0;
    hit       = 1'b0;
    first_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      tag_w   = row_cur[w*AW +: AW];
      match_w = vrow[w] && (tag_w == req_tag);
      if (!found && (32'(w) < 32'(ways_eff)) && (match_w || !vrow[w])) begin
        found     = 1'b1;
        hit       = match_w;
        first_way = WW'(w);
      end
    end

    wr_way  = found ? first_way : last_way;
    row_nxt = row_cur;
    row_nxt[wr_way*AW +: AW] = req_tag;
  end

  assign wr_en   = req.valid && !hit;
  assign wr_addr = sidx;
  assign wr_data = row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      byp_vld_r   <= 1'b0;
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else begin
      out_valid_r <= req.valid;
      byp_vld_r   <= wr_en;
      if (wr_en) begin
        valid_r[sidx][wr_way] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_set_r <= sidx;
      byp_row_r <= row_nxt;
    end
    if (req.valid) begin
      out_hit_r <= hit;
      out_tag_r <= req.tag;
      out_set_r <= req.set_idx;
      out_off_r <= req.offset;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_tag_value   = out_tag_r;
  assign out_set_index   = out_set_r;
  assign out_line_offset = out_off_r;

endmodule

`default_nettype wire

// ===== hdl/sacl_checker.sv =====
`default_nettype none

module sacl_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic [sacl_pkg::ADDR_W-1:0]       in_address,
  input wire logic                              out_valid,
  input wire logic                              out_hit,
  input wire logic [sacl_pkg::OFF_W-1:0]        out_line_offset,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready
);

  logic acc;
  logic cfg_wr;

  assign acc    = start && !busy;
  assign cfg_wr = cfg_valid && cfg_ready;

  // every beat taken gives exactly one strobe, after the request and output registers
  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(rst_n, 2)) |-> (out_valid == $past(acc, 2)))
    else $error("result strobe does not follow an accepted beat by two cycles");

  // a repeat of the previous address must hit (tests row forwarding)
  a_repeat_hits: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && acc && $past(acc) && (in_address == $past(in_address))
     && !cfg_wr && !$past(cfg_wr)) |=> ##1 out_hit)
    else $error("back-to-back repeat of an address missed");

  // the offset is a masked copy of the low address bits
  a_offset_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n) && $past(rst_n, 2)) |->
    ((out_line_offset & ~$past(in_address[5:0], 2)) == 6'd0))
    else $error("line offset holds bits not present in the address");

endmodule

bind set_assoc_cache_tag_lookup_top sacl_checker u_sacl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_address      (in_address),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_line_offset (out_line_offset),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready)
);

`default_nettype wire
